// ===== sv/rig_pkg.sv =====
// package for the radial influence grid splat: codes, constants, state type
`timescale 1ns / 1ps
`default_nettype none
package rig_pkg;
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF = 128;
    localparam int MAX_REACH_DEF = 64;
    localparam int FEATURE_REACH = 2;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_ALLY = 3'd1,
        OP_ENEMY = 3'd2,
        OP_FEATURE = 3'd3,
        OP_QUERY = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        REG_CELL_SIZE = 2'd0,
        REG_GRID_WIDTH = 2'd1,
        REG_GRID_HEIGHT = 2'd2,
        REG_INFL_BASE = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEL_ALLY = 2'd0,
        SEL_ENEMY = 2'd1,
        SEL_FEATURE = 2'd2
    } grid_sel_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_DISPATCH,
        ST_CLEAR,
        ST_SPLAT_RD,
        ST_SPLAT_CALC,
        ST_SPLAT_WR,
        ST_QUERY_RD,
        ST_QUERY_OUT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic clr_start;
        logic clr_step;
        logic spl_start;
        logic spl_next;
        logic spl_rd;
        logic spl_calc;
        logic spl_wr;
        logic qry_rd;
        logic qry_out;
        logic out_zero;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic clr_last;
        logic spl_empty;
        logic spl_last;
        logic spl_inside;
        logic calc_done;
        logic op_clear;
        logic op_add;
        logic op_query;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== sv/radial_influence_grid_splat.sv =====
// top level of the radial influence grid splat
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | op, pos_x, pos_z, strength, reach, ...
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  out     | output    | out_valid / out_ready | enemy_value, influence_value, outside_grid
// after reset a clearing pass over the grid memories runs before input is taken
// every item passes through the position dividers, one result word per item
// clear: one cell per cycle in the grid memories
// add: each window cell in range goes through the square root and weight divide; cells outside skip both
// query: a memory read, then the result register load; a pending result word stalls the input until taken
`timescale 1ns / 1ps
`default_nettype none
module radial_influence_grid_splat
    import rig_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_REACH = MAX_REACH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         op,
    input  wire logic [15:0]        pos_x,
    input  wire logic [15:0]        pos_z,
    input  wire logic [23:0]        strength,
    input  wire logic [6:0]         reach,
    input  wire logic               static_unit,
    input  wire logic               reclaimable,
    input  wire logic [8:0]         reclaim_left,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      enemy_value,
    output logic signed [31:0]      influence_value,
    output logic                    outside_grid,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);
    dp_cmd_t cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rig_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd));

    rig_datapath #(
        .MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .MAX_REACH(MAX_REACH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .op(op), .pos_x(pos_x), .pos_z(pos_z), .strength(strength), .reach(reach),
        .static_unit(static_unit), .reclaimable(reclaimable),
        .reclaim_left(reclaim_left), .enemy_value(enemy_value),
        .influence_value(influence_value), .outside_grid(outside_grid));
endmodule
`default_nettype wire

// ===== sv/rig_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rig_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== sv/rig_datapath.sv =====
// datapath: position divide, window walk, weight, grid memories and results
`timescale 1ns / 1ps
`default_nettype none
module rig_datapath
    import rig_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_REACH = MAX_REACH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    input  wire logic               cfg_valid,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic [2:0]         op,
    input  wire logic [15:0]        pos_x,
    input  wire logic [15:0]        pos_z,
    input  wire logic [23:0]        strength,
    input  wire logic [6:0]         reach,
    input  wire logic               static_unit,
    input  wire logic               reclaimable,
    input  wire logic [8:0]         reclaim_left,
    output logic signed [31:0]      enemy_value,
    output logic signed [31:0]      influence_value,
    output logic                    outside_grid
);
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int XW = $clog2(MAX_COLUMNS) > 0 ? $clog2(MAX_COLUMNS) : 1;
    localparam int ZW = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
    localparam int QW = $clog2(MAX_REACH + 1);
    localparam int SW = 2 * QW + 1;
    localparam int SQW = 2 * QW + 34;
    localparam int SQR = SQW / 2;
    localparam int NW = QW + 16;
    localparam logic [SQW-1:0] SQ_TOP = {2'b01, {(SQW-2){1'b0}}};

    // configuration
    logic [10:0] cell_size_reg;
    logic [7:0] grid_width_reg;
    logic [7:0] grid_height_reg;
    logic signed [23:0] infl_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= 11'd64;
            grid_width_reg <= 8'd64;
            grid_height_reg <= 8'd64;
            infl_base_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CELL_SIZE: cell_size_reg <= cfg_data[10:0];
                REG_GRID_WIDTH: grid_width_reg <= cfg_data[7:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[7:0];
                REG_INFL_BASE: infl_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    always_comb
    begin
        if (grid_width_reg == 8'd0)
            eff_w = CW'(1);
        else if (32'(grid_width_reg) > MAX_COLUMNS)
            eff_w = CW'(MAX_COLUMNS);
        else
            eff_w = CW'(grid_width_reg);
        if (grid_height_reg == 8'd0)
            eff_h = RW'(1);
        else if (32'(grid_height_reg) > MAX_ROWS)
            eff_h = RW'(MAX_ROWS);
        else
            eff_h = RW'(grid_height_reg);
    end

    // captured item
    op_t op_reg;
    logic [32:0] val_reg;
    logic [QW-1:0] r_reg;
    logic feat_on_reg;

    logic [QW-1:0] r_sat;
    logic [8:0] left_sat;
    always_comb
    begin
        r_sat = (32'(reach) > MAX_REACH) ? QW'(MAX_REACH) : QW'(reach);
        if (static_unit)
            r_sat = r_sat >> 1;
        left_sat = (reclaim_left > 9'd256) ? 9'd256 : reclaim_left;
    end

    // two restoring dividers, one quotient bit per cycle
    logic [15:0] qx_reg, qz_reg, rx_reg, rz_reg;
    logic [4:0] dcnt_reg;
    logic [10:0] cs_eff;
    logic [16:0] tx, tz;
    assign cs_eff = (cell_size_reg == 11'd0) ? 11'd1 : cell_size_reg;
    assign tx = {rx_reg, qx_reg[15]};
    assign tz = {rz_reg, qz_reg[15]};

    // feature value multiplier stage
    logic [32:0] fprod_reg;

    // window walk
    logic signed [17:0] x1_reg, z0_reg, z1_reg, x_reg, z_reg;
    logic signed [17:0] cx_s, cz_s;
    assign cx_s = {2'b00, qx_reg};
    assign cz_s = {2'b00, qz_reg};

    logic signed [17:0] rs;
    logic signed [17:0] x0_c, x1_c, z0_c, z1_c;
    always_comb
    begin
        rs = 18'(r_reg);
        x0_c = cx_s - rs + 18'sd1;
        if (x0_c < 0) x0_c = '0;
        x1_c = cx_s + rs;
        if (x1_c > 18'(eff_w)) x1_c = 18'(eff_w);
        z0_c = cz_s - rs + 18'sd1;
        if (z0_c < 0) z0_c = '0;
        z1_c = cz_s + rs;
        if (z1_c > 18'(eff_h)) z1_c = 18'(eff_h);
    end

    logic [AW-1:0] addr;
    logic [AW-1:0] clr_addr_reg;
    logic signed [17:0] dx, dz;
    logic [SW-1:0] len_sq_reg;
    logic inside_reg;
    assign dx = cx_s - x_reg;
    assign dz = cz_s - z_reg;

    // weight: sqrt iterations, then divide iterations, then a multiply by the item value
    logic [SQW-1:0] sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [NW-1:0] num_reg;
    logic [16:0] wq_reg;
    logic [QW-1:0] wr_reg;
    logic [4:0] wcnt_reg;
    logic [1:0] phase_reg;
    logic [49:0] mul_reg;
    logic [QW:0] wt;
    assign wt = {wr_reg, num_reg[NW-1]};

    // memories
    logic signed [31:0] ally_q, enemy_q, feat_q, wdata;
    logic we_a, we_e, we_f;
    rig_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ally (
        .clk(clk), .we(we_a), .addr(addr), .wdata(wdata), .rdata(ally_q));
    rig_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_enemy (
        .clk(clk), .we(we_e), .addr(addr), .wdata(wdata), .rdata(enemy_q));
    rig_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_feat (
        .clk(clk), .we(we_f), .addr(addr), .wdata(wdata), .rdata(feat_q));

    logic signed [31:0] cur;
    logic signed [33:0] sum;
    always_comb
    begin
        case (op_reg)
            OP_ALLY: cur = ally_q;
            OP_ENEMY: cur = enemy_q;
            default: cur = feat_q;
        endcase
        sum = 34'(cur) + 34'(mul_reg[49:16]);
    end

    logic [ZW-1:0] zi;
    logic [XW-1:0] xi;
    assign zi = ZW'(z_reg);
    assign xi = XW'(x_reg);

    always_comb
    begin
        if (cmd.clr_step)
            addr = clr_addr_reg;
        else if (cmd.qry_rd)
            addr = AW'(32'(qz_reg) * MAX_COLUMNS + 32'(qx_reg));
        else
            addr = AW'(32'(zi) * MAX_COLUMNS + 32'(xi));
        if (cmd.clr_step)
            wdata = 32'(infl_base_reg);
        else if (sum > 34'sh7fffffff)
            wdata = 32'h7fffffff;
        else
            wdata = sum[31:0];
        we_a = cmd.clr_step || (cmd.spl_wr && inside_reg && op_reg == OP_ALLY);
        we_e = cmd.clr_step || (cmd.spl_wr && inside_reg && op_reg == OP_ENEMY);
        we_f = cmd.clr_step || (cmd.spl_wr && inside_reg && op_reg == OP_FEATURE);
    end

    logic [SQW-1:0] sq_t;
    assign sq_t = sq_res_reg + sq_bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op_t'(op);
            fprod_reg <= 33'(strength) * 33'(left_sat);
            val_reg <= 33'(strength);
            r_reg <= (op == OP_FEATURE) ? QW'(FEATURE_REACH) : r_sat;
            feat_on_reg <= reclaimable;
            qx_reg <= pos_x;
            qz_reg <= pos_z;
            rx_reg <= '0;
            rz_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            if (tx >= 17'(cs_eff))
            begin
                rx_reg <= 16'(tx - 17'(cs_eff));
                qx_reg <= {qx_reg[14:0], 1'b1};
            end
            else
            begin
                rx_reg <= tx[15:0];
                qx_reg <= {qx_reg[14:0], 1'b0};
            end
            if (tz >= 17'(cs_eff))
            begin
                rz_reg <= 16'(tz - 17'(cs_eff));
                qz_reg <= {qz_reg[14:0], 1'b1};
            end
            else
            begin
                rz_reg <= tz[15:0];
                qz_reg <= {qz_reg[14:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 5'd1;
        end
        if (cmd.spl_start)
        begin
            if (op_reg == OP_FEATURE)
                val_reg <= fprod_reg >> 8;
            x1_reg <= x1_c;
            z0_reg <= z0_c;
            z1_reg <= z1_c;
            x_reg <= x0_c;
            z_reg <= z0_c;
        end
        else if (cmd.spl_next)
        begin
            if (z_reg + 18'sd1 >= z1_reg)
            begin
                z_reg <= z0_reg;
                x_reg <= x_reg + 18'sd1;
            end
            else
                z_reg <= z_reg + 18'sd1;
        end
        if (cmd.clr_start)
            clr_addr_reg <= '0;
        else if (cmd.clr_step)
            clr_addr_reg <= clr_addr_reg + AW'(1);
        if (cmd.spl_rd)
        begin
            len_sq_reg <= SW'(dx * dx + dz * dz);
            inside_reg <= (dx * dx + dz * dz) <= 36'(rs * rs);
            phase_reg <= 2'd0;
        end
        else if (cmd.spl_calc)
        begin
            case (phase_reg)
                2'd0:
                begin
                    sq_n_reg <= SQW'(len_sq_reg) << 32;
                    sq_res_reg <= '0;
                    sq_bit_reg <= SQ_TOP;
                    phase_reg <= 2'd1;
                end
                2'd1:
                begin
                    if (sq_bit_reg == '0)
                    begin
                        num_reg <= NW'((32'(r_reg) << 16) - 32'(sq_res_reg));
                        wr_reg <= '0;
                        wq_reg <= '0;
                        wcnt_reg <= '0;
                        phase_reg <= 2'd2;
                    end
                    else
                    begin
                        if (sq_n_reg >= sq_t)
                        begin
                            sq_n_reg <= sq_n_reg - sq_t;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end
                        else
                            sq_res_reg <= sq_res_reg >> 1;
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                end
                2'd2:
                begin
                    if (wt >= (QW+1)'(r_reg))
                    begin
                        wr_reg <= QW'(wt - (QW+1)'(r_reg));
                        wq_reg <= {wq_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        wr_reg <= wt[QW-1:0];
                        wq_reg <= {wq_reg[15:0], 1'b0};
                    end
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                    wcnt_reg <= wcnt_reg + 5'd1;
                    if (wcnt_reg == 5'(NW - 1))
                        phase_reg <= 2'd3;
                end
                default:
                begin
                    mul_reg <= 50'(val_reg) * 50'(wq_reg);
                end
            endcase
        end
    end

    // result register
    logic signed [33:0] e_s, f_s;
    always_comb
    begin
        e_s = 34'(enemy_q) - 34'(infl_base_reg);
        f_s = 34'(ally_q) - 34'(enemy_q) - 34'(infl_base_reg);
    end

    function automatic logic [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sh7fffffff)
            return 32'h7fffffff;
        else if (v < -34'sh80000000)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

    logic qry_out_of;
    assign qry_out_of = (32'(qx_reg) >= 32'(eff_w)) || (32'(qz_reg) >= 32'(eff_h));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enemy_value <= '0;
            influence_value <= '0;
            outside_grid <= 1'b0;
        end
        else if (cmd.out_zero)
        begin
            enemy_value <= '0;
            influence_value <= '0;
            outside_grid <= 1'b0;
        end
        else if (cmd.qry_out)
        begin
            outside_grid <= qry_out_of;
            enemy_value <= qry_out_of ? '0 : sat(e_s);
            influence_value <= qry_out_of ? '0 : sat(f_s);
        end
    end

    always_comb
    begin
        stat.div_done = (dcnt_reg == 5'd16);
        stat.clr_last = (clr_addr_reg == AW'(DEPTH - 1));
        stat.spl_empty = (r_reg == '0) || (x0_c >= x1_c) || (z0_c >= z1_c)
            || (op_reg == OP_FEATURE && !feat_on_reg);
        stat.spl_last = (x_reg + 18'sd1 >= x1_reg) && (z_reg + 18'sd1 >= z1_reg);
        stat.spl_inside = inside_reg;
        stat.calc_done = (phase_reg == 2'd3);
        stat.op_clear = (op_reg == OP_CLEAR);
        stat.op_add = (op_reg == OP_ALLY) || (op_reg == OP_ENEMY)
            || (op_reg == OP_FEATURE);
        stat.op_query = (op_reg == OP_QUERY);
    end

`ifndef NO_ASSERTIONS
    a_no_clr_and_spl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_step && cmd.spl_wr))
        else $error("clear and splat write together");
    a_wr_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.spl_wr && inside_reg) |-> (x_reg < x1_reg && z_reg < z1_reg))
        else $error("splat write outside window");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> dcnt_reg < 5'd16)
        else $error("divider overrun");
`endif
endmodule
`default_nettype wire

// ===== sv/rig_ctrl.sv =====
// controller state machine
`timescale 1ns / 1ps
`default_nettype none
module rig_ctrl
    import rig_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);
    state_t state_reg, state_next;
    logic clr_first_reg, clr_first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            clr_first_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            clr_first_reg <= clr_first_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_first_next = clr_first_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                clr_first_next = 1'b0;
                if (clr_first_reg)
                    cmd.clr_step = 1'b0;
                if (clr_first_reg)
                    cmd.clr_start = 1'b1;
                else if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = ST_DISPATCH;
                else
                    cmd.div_start = 1'b1;
            end
            ST_DISPATCH:
            begin
                if (stat.op_clear)
                begin
                    cmd.clr_start = 1'b1;
                    state_next = ST_CLEAR;
                end
                else if (stat.op_add)
                begin
                    cmd.spl_start = 1'b1;
                    if (stat.spl_empty)
                    begin
                        cmd.out_zero = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                        state_next = ST_SPLAT_RD;
                end
                else if (stat.op_query)
                begin
                    cmd.qry_rd = 1'b1;
                    state_next = ST_QUERY_OUT;
                end
                else
                begin
                    cmd.out_zero = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.out_zero = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SPLAT_RD:
            begin
                cmd.spl_rd = 1'b1;
                state_next = ST_SPLAT_CALC;
            end
            ST_SPLAT_CALC:
            begin
                if (!stat.spl_inside)
                    state_next = ST_SPLAT_WR;
                else
                begin
                    cmd.spl_calc = 1'b1;
                    if (stat.calc_done)
                        state_next = ST_SPLAT_WR;
                end
            end
            ST_SPLAT_WR:
            begin
                cmd.spl_wr = 1'b1;
                if (stat.spl_last)
                begin
                    cmd.out_zero = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.spl_next = 1'b1;
                    state_next = ST_SPLAT_RD;
                end
            end
            ST_QUERY_RD:
            begin
                state_next = ST_QUERY_OUT;
            end
            ST_QUERY_OUT:
            begin
                cmd.qry_out = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while word pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped");
    a_wr_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.spl_wr |-> $past(state_reg) == ST_SPLAT_CALC)
        else $error("write without weight");
`endif
endmodule
`default_nettype wire
